// ===== hw/rtl/gtfi_pkg.sv =====
package gtfi_pkg;

  // Operation codes carried in the op field of an input word
  typedef enum logic [1:0] {
    OP_WR_CURVE = 2'd0,
    OP_WR_HINT  = 2'd1,
    OP_FWD      = 2'd2,
    OP_REV      = 2'd3
  } op_t;

  localparam int unsigned HINT_ENTRIES = 256;
  localparam logic [15:0] CONV_MAX     = 16'hffff;
  localparam logic [8:0]  WALK_TOP     = 9'd255;
  localparam logic [4:0]  DIV_LAST     = 5'd31;

endpackage

// ===== hw/rtl/gtfi_ram.sv =====
module gtfi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/gamma_table_forward_inverse.sv =====
// A reverse conversion takes longer the more curve entries its walk compares, and a zero step
// skips the divider; output stalls add to the time of any conversion.
// One word in work at a time; the next is taken the cycle after the result reaches
// the output register. The forward fetch, the walk and the base and step reads share the curve RAM port.
// rst_n (sync, active low) clears sequencer and output valid; tables are not cleared.
module gamma_table_forward_inverse
  import gtfi_pkg::*;
#(
  parameter int CURVE_ENTRIES = 257
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [8:0]  in_entry_index,
  input  logic [15:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_converted
);

  localparam int AW = $clog2(CURVE_ENTRIES);
  localparam int HW = $clog2(HINT_ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE,
    S_F_RD0,
    S_F_RD1,
    S_F_MUL,
    S_F_SUM,
    S_R_HINT,
    S_R_HWAIT,
    S_R_DN_RD,
    S_R_DN_CMP,
    S_R_UP_RD,
    S_R_UP_CMP,
    S_R_BASE,
    S_R_BASE2,
    S_R_STEP,
    S_R_DIV,
    S_R_SUM,
    S_DONE
  } state_t;

  state_t      state_r, state_nxt;
  logic [15:0] x_r, x_nxt;
  logic [8:0]  y_r, y_nxt;
  logic [15:0] base_r, base_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [31:0] num_r, num_nxt;
  logic [31:0] step_r, step_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [15:0] res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_converted_r, out_converted_nxt;

  logic          in_acc;
  logic          curve_we, hint_we;
  logic [AW-1:0] curve_waddr, curve_raddr;
  logic [15:0]   curve_rdata;
  logic [7:0]    hint_rdata;

  logic [31:0] diff, sub_arg, prod_full, sum;
  logic [32:0] rem_sh;

  // Clamp a curve index to the last entry
  function automatic logic [AW-1:0] clamp_idx(input logic [8:0] i);
    if (32'(i) >= CURVE_ENTRIES) begin
      return AW'(CURVE_ENTRIES - 1);
    end
    return AW'(i);
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_converted = out_converted_r;

  // Table writes happen on the accepting edge
  assign curve_we    = in_acc && (in_op == OP_WR_CURVE) && (32'(in_entry_index) < CURVE_ENTRIES);
  assign hint_we     = in_acc && (in_op == OP_WR_HINT) && !in_entry_index[8];
  assign curve_waddr = AW'(in_entry_index);

  gtfi_ram #(.WIDTH(16), .DEPTH(CURVE_ENTRIES)) u_curve (
    .clk   (clk),
    .we    (curve_we),
    .waddr (curve_waddr),
    .wdata (in_value),
    .raddr (curve_raddr),
    .rdata (curve_rdata)
  );

  gtfi_ram #(.WIDTH(8), .DEPTH(HINT_ENTRIES)) u_hint (
    .clk   (clk),
    .we    (hint_we),
    .waddr (in_entry_index[HW-1:0]),
    .wdata (in_value[7:0]),
    .raddr (x_r[15:8]),
    .rdata (hint_rdata)
  );

  // Shared datapath: one subtractor on the RAM word, one narrow multiply,
  // one divider step
  assign diff      = {16'd0, curve_rdata} - {16'd0, base_r};
  assign sub_arg   = {16'd0, x_r} - {16'd0, base_r};
  assign prod_full = diff * {24'd0, x_r[7:0]};
  assign rem_sh    = {rem_r, num_r[31]};
  assign sum       = (state_r == S_F_SUM) ? ({16'd0, base_r} + {8'd0, prod_r[31:8]})
                                          : (num_r + {15'd0, y_r, 8'd0});

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    base_nxt    = base_r;
    prod_nxt    = prod_r;
    num_nxt     = num_r;
    step_nxt    = step_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    res_nxt     = res_r;
    curve_raddr = '0;
    out_valid_nxt     = out_valid_r;
    out_converted_nxt = out_converted_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          x_nxt = in_value;
          unique case (in_op)
            OP_FWD: state_nxt = S_F_RD0;
            OP_REV: state_nxt = S_R_HINT;
            default: begin
              res_nxt   = '0;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      // forward: fetch two neighbours, multiply, add
      S_F_RD0: begin
        curve_raddr = clamp_idx({1'b0, x_r[15:8]});
        state_nxt   = S_F_RD1;
      end
      S_F_RD1: begin
        curve_raddr = clamp_idx({1'b0, x_r[15:8]} + 9'd1);
        base_nxt    = curve_rdata;
        state_nxt   = S_F_MUL;
      end
      S_F_MUL: begin
        prod_nxt  = prod_full;
        state_nxt = S_F_SUM;
      end
      S_F_SUM: begin
        res_nxt   = (|sum[31:16]) ? CONV_MAX : sum[15:0];
        state_nxt = S_DONE;
      end
      // reverse: hint lookup
      S_R_HINT: begin
        state_nxt = S_R_HWAIT;
      end
      S_R_HWAIT: begin
        y_nxt     = (hint_rdata == 8'd0) ? 9'd0 : ({1'b0, hint_rdata} - 9'd1);
        state_nxt = S_R_DN_RD;
      end
      // walk down while the entry is above the argument
      S_R_DN_RD: begin
        if (y_r == 9'd0) begin
          y_nxt     = 9'd1;
          state_nxt = S_R_UP_RD;
        end else begin
          curve_raddr = clamp_idx(y_r);
          state_nxt   = S_R_DN_CMP;
        end
      end
      S_R_DN_CMP: begin
        if (curve_rdata > x_r) begin
          y_nxt     = y_r - 9'd1;
          state_nxt = S_R_DN_RD;
        end else begin
          y_nxt     = y_r + 9'd1;
          state_nxt = S_R_UP_RD;
        end
      end
      // walk up while the entry is not above the argument
      S_R_UP_RD: begin
        if (y_r >= WALK_TOP) begin
          y_nxt     = y_r - 9'd1;
          state_nxt = S_R_BASE;
        end else begin
          curve_raddr = clamp_idx(y_r);
          state_nxt   = S_R_UP_CMP;
        end
      end
      S_R_UP_CMP: begin
        if (curve_rdata <= x_r) begin
          y_nxt     = y_r + 9'd1;
          state_nxt = S_R_UP_RD;
        end else begin
          y_nxt     = y_r - 9'd1;
          state_nxt = S_R_BASE;
        end
      end
      // base and step around the found entry
      S_R_BASE: begin
        curve_raddr = clamp_idx(y_r);
        state_nxt   = S_R_BASE2;
      end
      S_R_BASE2: begin
        curve_raddr = clamp_idx(y_r + 9'd1);
        base_nxt    = curve_rdata;
        state_nxt   = S_R_STEP;
      end
      S_R_STEP: begin
        step_nxt = diff;
        rem_nxt  = '0;
        cnt_nxt  = '0;
        if (diff == 32'd0) begin
          num_nxt   = '0;
          state_nxt = S_R_SUM;
        end else begin
          num_nxt   = {sub_arg[23:0], 8'd0};
          state_nxt = S_R_DIV;
        end
      end
      // restoring division, one quotient bit a cycle
      S_R_DIV: begin
        if (rem_sh >= {1'b0, step_r}) begin
          rem_nxt = 32'(rem_sh - {1'b0, step_r});
          num_nxt = {num_r[30:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[31:0];
          num_nxt = {num_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_R_SUM;
        end
      end
      S_R_SUM: begin
        if (sum[31]) begin
          res_nxt = '0;
        end else if (|sum[30:16]) begin
          res_nxt = CONV_MAX;
        end else begin
          res_nxt = sum[15:0];
        end
        state_nxt = S_DONE;
      end
      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt     = 1'b1;
          out_converted_nxt = res_r;
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r             <= x_nxt;
    y_r             <= y_nxt;
    base_r          <= base_nxt;
    prod_r          <= prod_nxt;
    num_r           <= num_nxt;
    step_r          <= step_nxt;
    rem_r           <= rem_nxt;
    cnt_r           <= cnt_nxt;
    res_r           <= res_nxt;
    out_converted_r <= out_converted_nxt;
  end

endmodule

// ===== hw/rtl/gtfi_checker.sv =====
module gtfi_checker
  import gtfi_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_op,
  input logic [8:0]  in_entry_index,
  input logic [15:0] in_value,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_converted
);

  logic       in_acc, out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;

  // Words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_r <= pend_r - 2'd1;
    end
  end

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_converted))
    else $error("result changed while stalled");

  // One word in work at a time
  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input taken again straight after accept");

  // No result without an accepted word behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result with nothing outstanding");

  // At most one word in work plus one waiting in the output register
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many words outstanding");

endmodule

bind gamma_table_forward_inverse gtfi_checker u_gtfi_checker (.*);

// ===== sim/gamma_table_forward_inverse_tb.sv =====
`timescale 1ns / 100ps

module gamma_table_forward_inverse_tb;
  import gtfi_pkg::*;

  localparam int CURVE_ENTRIES = 257;
  localparam int RANDOM_WORDS  = 360;
  localparam int DRAIN_CYCLES  = 600;

  // one input word with the idling phase it is sent in
  typedef struct {
    op_t         op;
    logic [8:0]  entry_index;
    logic [15:0] value;
    int          phase;
  } conv_word_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op          = OP_WR_CURVE;
  logic [8:0]  in_entry_index = '0;
  logic [15:0] in_value       = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [15:0] out_converted;

  conv_word_t  word_q[$];
  logic [15:0] converted_q[$];
  int          total_words;
  int          words_accepted = 0;
  int          error_count    = 0;
  int          send_idle      = 31;
  int          recv_idle      = 71;

  // mirror of the two tables
  logic [15:0] curve_mirror[0:CURVE_ENTRIES-1];
  logic [7:0]  hint_mirror[0:HINT_ENTRIES-1];

  gamma_table_forward_inverse #(
    .CURVE_ENTRIES(CURVE_ENTRIES)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_entry_index(in_entry_index),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_converted (out_converted)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // curve read, clamped to the last entry
  function automatic bit [31:0] curve_at(bit [31:0] i);
    if (i >= CURVE_ENTRIES) i = CURVE_ENTRIES - 1;
    return {16'd0, curve_mirror[i]};
  endfunction

  // apply one word to the mirror and return the converted value it yields
  function automatic logic [15:0] convert_word(op_t op, logic [8:0] idx, logic [15:0] val);
    bit [31:0] x, y, base, diff, prod, step, num, quot, sum;
    logic [15:0] res;
    x   = {16'd0, val};
    res = '0;
    case (op)
      OP_WR_CURVE: begin
        if (idx < CURVE_ENTRIES) curve_mirror[idx] = val;
      end
      OP_WR_HINT: begin
        if (idx < HINT_ENTRIES) hint_mirror[idx[7:0]] = val[7:0];
      end
      OP_FWD: begin
        // linear step toward the next entry, 32-bit wrap, then saturate
        y    = {24'd0, val[15:8]};
        base = curve_at(y);
        diff = curve_at(y + 1) - base;
        prod = diff * {24'd0, val[7:0]};
        sum  = base + (prod >> 8);
        res  = (sum > CONV_MAX) ? CONV_MAX : sum[15:0];
      end
      default: begin
        // walk down from the hint, then up to the last entry not above x
        y = {24'd0, hint_mirror[val[15:8]]};
        if (y > 0) y = y - 1;
        while (y > 0 && curve_at(y) > x) y = y - 1;
        y = y + 1;
        while (y < WALK_TOP && curve_at(y) <= x) y = y + 1;
        y    = y - 1;
        base = curve_at(y);
        step = curve_at(y + 1) - base;
        quot = 0;
        if (step != 0) begin
          num  = (x - base) << 8;
          quot = num / step;
        end
        sum = quot + (y << 8);
        if (sum[31]) res = '0;
        else if (sum > CONV_MAX) res = CONV_MAX;
        else res = sum[15:0];
      end
    endcase
    return res;
  endfunction

  function automatic void queue_word(op_t op, logic [8:0] idx, logic [15:0] val, int phase);
    conv_word_t w;
    w.op          = op;
    w.entry_index = idx;
    w.value       = val;
    w.phase       = phase;
    word_q.push_back(w);
  endfunction

  // driver: next word goes out once the previous one is taken
  always @(posedge clk) begin : drive_proc
    conv_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        converted_q.push_back(convert_word(op_t'(in_op), in_entry_index, in_value));
        words_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (word_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          w = word_q.pop_front();
          in_op          <= w.op;
          in_entry_index <= w.entry_index;
          in_value       <= w.value;
          in_valid       <= 1'b1;
          send_idle      <= (w.phase == 0) ? 31 : (w.phase == 1) ? 71 : 0;
          recv_idle      <= (w.phase == 0) ? 71 : (w.phase == 1) ? 31 : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result word against the oldest expectation
  always @(posedge clk) begin : check_proc
    logic [15:0] exp_conv;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (converted_q.size() == 0) begin
          $error("unexpected result word, converted %h", out_converted);
          error_count++;
        end else begin
          exp_conv = converted_q.pop_front();
          if (out_converted !== exp_conv) begin
            $error("converted: expected %h, actual %h", exp_conv, out_converted);
            error_count++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // stimulus and end of run
  initial begin : stim_proc
    logic [15:0] load_curve[0:CURVE_ENTRIES-1];
    bit [31:0]   c;
    int          j;
    int          r;
    int          phase;
    logic [8:0]  idx;
    logic [15:0] val;

    // load a rising curve with random steps, then matching hints
    c = $urandom_range(0, 128);
    for (int i = 0; i < CURVE_ENTRIES; i++) begin
      load_curve[i] = c[15:0];
      queue_word(OP_WR_CURVE, 9'(i), c[15:0], 0);
      c = c + $urandom_range(0, 511);
      if (c > CONV_MAX) c = CONV_MAX;
    end
    j = 0;
    for (int h = 0; h < HINT_ENTRIES; h++) begin
      while (j < 255 && load_curve[j + 1] <= (h << 8)) j++;
      queue_word(OP_WR_HINT, 9'(h), {8'($urandom), 8'(j)}, 0);
    end

    // directed words
    queue_word(OP_FWD, 9'd0, 16'h0000, 0);
    queue_word(OP_FWD, 9'd0, 16'hffff, 0);
    queue_word(OP_REV, 9'd0, 16'h0000, 0);
    queue_word(OP_REV, 9'd0, 16'hffff, 0);
    queue_word(OP_REV, 9'd0, 16'h8000, 0);
    // writes past the end of either table are dropped
    queue_word(OP_WR_CURVE, 9'd257, 16'h1234, 0);
    queue_word(OP_WR_CURVE, 9'd511, 16'hffff, 0);
    queue_word(OP_WR_HINT, 9'd256, 16'hffff, 0);
    queue_word(OP_WR_HINT, 9'd511, 16'h00aa, 0);
    // hint keeps only the low byte
    queue_word(OP_WR_HINT, 9'd0, 16'hff00, 0);
    // argument below entry 0: step of one gives a negative sum
    queue_word(OP_WR_CURVE, 9'd0, 16'h0040, 0);
    queue_word(OP_WR_CURVE, 9'd1, 16'h0041, 0);
    queue_word(OP_REV, 9'd0, 16'h0000, 0);
    // wider step gives an overlarge positive sum
    queue_word(OP_WR_CURVE, 9'd1, 16'h0140, 0);
    queue_word(OP_REV, 9'd0, 16'h003f, 0);
    // falling curve in forward
    queue_word(OP_WR_CURVE, 9'd10, 16'hffff, 0);
    queue_word(OP_WR_CURVE, 9'd11, 16'h0000, 0);
    queue_word(OP_FWD, 9'd0, 16'h0a80, 0);
    queue_word(OP_FWD, 9'd0, 16'h0aff, 0);
    // flat step at the top of the walk, then a falling one
    queue_word(OP_WR_CURVE, 9'd254, 16'hff40, 0);
    queue_word(OP_WR_CURVE, 9'd255, 16'hff40, 0);
    queue_word(OP_REV, 9'd0, 16'hffff, 0);
    queue_word(OP_WR_CURVE, 9'd255, 16'h0000, 0);
    queue_word(OP_REV, 9'd0, 16'hffff, 0);
    queue_word(OP_WR_CURVE, 9'd256, 16'h0000, 0);
    queue_word(OP_FWD, 9'd0, 16'hff80, 0);

    // random words: mostly conversions on a near-rising curve, some noise
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      phase = (i < RANDOM_WORDS / 3) ? 0 : (i < 2 * RANDOM_WORDS / 3) ? 1 : 2;
      r = $urandom_range(0, 99);
      if (r < 35) begin
        queue_word(OP_REV, 9'($urandom), 16'($urandom), phase);
      end else if (r < 65) begin
        queue_word(OP_FWD, 9'($urandom), 16'($urandom), phase);
      end else if (r < 85) begin
        idx = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(257, 511))
                                          : 9'($urandom_range(0, 256));
        if ($urandom_range(0, 9) < 7) begin
          c = (idx << 8) + $urandom_range(0, 255);
          if (c > CONV_MAX) c = CONV_MAX;
          val = c[15:0];
        end else begin
          val = 16'($urandom);
        end
        queue_word(OP_WR_CURVE, idx, val, phase);
      end else begin
        idx = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(256, 511))
                                          : 9'($urandom_range(0, 255));
        val = 16'($urandom);
        if ($urandom_range(0, 9) < 7)
          val[7:0] = (idx == 0) ? 8'd0 : 8'(idx - 1 + $urandom_range(0, 1));
        queue_word(OP_WR_HINT, idx, val, phase);
      end
    end
    total_words = word_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (words_accepted < total_words || converted_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && converted_q.size() == 0) begin
      $display("gamma_table_forward_inverse_tb passed");
    end else begin
      $display("gamma_table_forward_inverse_tb failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("gamma_table_forward_inverse_tb failed");
    $finish;
  end

endmodule
